[rtl/core/lcp_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and control structures for the LRU directory.
// Used by lcp_cell, lcp_match_tree and lru_cache_with_prefetch_top.
package lcp_pkg;

    // Directory size and key width.
    localparam int MAX_ENTRIES = 64;
    localparam int KEY_BITS    = 32;

    // Derived widths.
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W = 7;
    localparam int CMP_W = (CAP_W > OCC_W) ? CAP_W : OCC_W;
    localparam int CNT_W = 32;

    // Capacity after reset, limited to the directory size.
    localparam int CAP_RESET = (64 > MAX_ENTRIES) ? MAX_ENTRIES : 64;

    // Command field.
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_FETCH    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PREFETCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PROBE    = 2'd2;

    // Stream widths, padded to whole bytes.
    localparam int IN_RAW_W  = CMD_W + KEY_BITS;
    localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = 3 + KEY_BITS + 1 + 3 * CNT_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    // Update performed by the row of cells.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_FETCH_HIT,
        OP_FETCH_INS,
        OP_FETCH_EVICT,
        OP_PRE_INS,
        OP_PRE_EVICT
    } cell_op_t;

    // Control broadcast to every cell.
    typedef struct packed {
        cell_op_t            op;
        logic [IDX_W-1:0]    hit_idx;
        logic [IDX_W-1:0]    last_idx;
        logic [OCC_W-1:0]    occ;
        logic [KEY_BITS-1:0] key;
    } cell_ctrl_t;

endpackage

[rtl/core/lru_cache_with_prefetch_top.sv]
`timescale 1ns / 1ps
// Fully associative LRU key directory with prefetch, built as a row of cells.
// Depends on lcp_pkg, lcp_cell and lcp_match_tree.
//
// Usage:
//   The input stream carries one request per transfer: tdata holds the command
//   (fetch, prefetch or probe) and the node key, tlast marks the last probe of
//   a membership group. The output stream returns exactly one result per
//   request: hit, load request, evicted key, group result and the three
//   counters after the request.
//   The accept cycle compares the key against all cells at once, and the update
//   state, once the output register is free, shifts the row of cells, in which
//   every cell takes its key from itself, a neighbor or the request. The next
//   request is accepted only after the update, so the block does not take a new
//   request before it is through with the last one.
//   The result sits in an output register; a new request is accepted while it
//   waits, but the update cycle holds until the output register is free, so a
//   stalled receiver stalls the input after one more request.
//   The capacity register is written over the cfg channel while the block is
//   idle; writing a value that differs after clamping empties the directory.
//   Reset empties the directory, clears the counters and sets capacity to 64.
module lru_cache_with_prefetch_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream. tdata: command [1:0], node_key [33:2], zero padding above.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lcp_pkg::IN_W-1:0]      s_tdata,
    input  logic                          s_tlast,      // group_last
    // Result stream. tdata: hit [0], load_needed [1], evicted_valid [2],
    // evicted_key [34:3], all_present [35], hit_count [67:36],
    // miss_count [99:68], prefetch_count [131:100], zero padding above.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lcp_pkg::OUT_W-1:0]     m_tdata,
    // Capacity register write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lcp_pkg::CAP_W-1:0]     cfg_data
);

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    localparam int N  = lcp_pkg::MAX_ENTRIES;
    localparam int KB = lcp_pkg::KEY_BITS;

    state_t                          state_reg;
    logic [lcp_pkg::CMD_W-1:0]       cmd_reg;
    logic [KB-1:0]                   key_reg;
    logic                            last_reg;
    logic                            hit_reg;
    logic [lcp_pkg::IDX_W-1:0]       hit_idx_reg;
    logic [lcp_pkg::OCC_W-1:0]       cap_reg;
    logic [lcp_pkg::OCC_W-1:0]       occ_reg;
    logic [lcp_pkg::CNT_W-1:0]       hits_reg;
    logic [lcp_pkg::CNT_W-1:0]       misses_reg;
    logic [lcp_pkg::CNT_W-1:0]       prefetches_reg;
    logic                            group_reg;
    logic                            m_tvalid_reg;
    logic [lcp_pkg::OUT_W-1:0]       m_tdata_reg;

    logic [KB-1:0]                   cell_key   [N];
    logic                            cell_valid [N];
    logic [N-1:0]                    cell_match;
    logic                            lookup_hit;
    logic [lcp_pkg::IDX_W-1:0]       lookup_idx;
    lcp_pkg::cell_ctrl_t             ctrl;

    logic                            s_fire;
    logic                            cfg_fire;
    logic                            upd_fire;
    logic                            full;
    logic [lcp_pkg::CMP_W-1:0]       cap_wide;
    logic [lcp_pkg::OCC_W-1:0]       cap_next;

    logic [lcp_pkg::OCC_W-1:0]       occ_next;
    logic [lcp_pkg::CNT_W-1:0]       hits_next;
    logic [lcp_pkg::CNT_W-1:0]       misses_next;
    logic [lcp_pkg::CNT_W-1:0]       prefetches_next;
    logic                            group_next;
    logic                            res_hit;
    logic                            res_load;
    logic                            res_ev;
    logic [KB-1:0]                   res_ev_key;
    logic                            res_allp;
    logic                            group_and;
    logic [lcp_pkg::OUT_W-1:0]       m_tdata_next;

    // Handshakes; nothing is taken while reset is held.
    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign cfg_ready = aresetn && (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign upd_fire  = (state_reg == ST_UPDATE) && (!m_tvalid_reg || m_tready);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign full = (occ_reg >= cap_reg);

    // Capacity clamp: zero reads as one, values above the directory size
    // read as the directory size.
    always_comb begin
        cap_wide = lcp_pkg::CMP_W'(cfg_data);
        if (cap_wide == '0) begin
            cap_wide = lcp_pkg::CMP_W'(1);
        end else if (cap_wide > lcp_pkg::CMP_W'(lcp_pkg::MAX_ENTRIES)) begin
            cap_wide = lcp_pkg::CMP_W'(lcp_pkg::MAX_ENTRIES);
        end
        cap_next = lcp_pkg::OCC_W'(cap_wide);
    end

    // Row of cells; cell 0 holds the least recent key.
    for (genvar j = 0; j < N; j++) begin : g_cell
        logic [KB-1:0] up_key;
        logic [KB-1:0] dn_key;
        logic          dn_valid;

        if (j == N - 1) begin : g_top
            assign up_key = '0;
        end else begin : g_mid_up
            assign up_key = cell_key[j+1];
        end

        if (j == 0) begin : g_bottom
            assign dn_key   = '0;
            assign dn_valid = 1'b0;
        end else begin : g_mid_dn
            assign dn_key   = cell_key[j-1];
            assign dn_valid = cell_valid[j-1];
        end

        lcp_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .idx        (lcp_pkg::IDX_W'(j)),
            .lookup_key (s_tdata[lcp_pkg::CMD_W +: KB]),
            .ctrl       (ctrl),
            .up_key     (up_key),
            .dn_key     (dn_key),
            .dn_valid   (dn_valid),
            .key        (cell_key[j]),
            .valid      (cell_valid[j]),
            .match      (cell_match[j])
        );
    end

    lcp_match_tree u_match_tree (
        .match   (cell_match),
        .hit     (lookup_hit),
        .hit_idx (lookup_idx)
    );

    // Control for the row of cells.
    always_comb begin
        ctrl.op       = lcp_pkg::OP_HOLD;
        ctrl.hit_idx  = hit_idx_reg;
        ctrl.last_idx = lcp_pkg::IDX_W'(occ_reg - lcp_pkg::OCC_W'(1));
        ctrl.occ      = occ_reg;
        ctrl.key      = key_reg;
        if (cfg_fire && (cap_next != cap_reg)) begin
            ctrl.op = lcp_pkg::OP_CLEAR;
        end else if (upd_fire) begin
            case (cmd_reg)
                lcp_pkg::CMD_FETCH: begin
                    if (hit_reg) begin
                        ctrl.op = lcp_pkg::OP_FETCH_HIT;
                    end else if (full) begin
                        ctrl.op = lcp_pkg::OP_FETCH_EVICT;
                    end else begin
                        ctrl.op = lcp_pkg::OP_FETCH_INS;
                    end
                end
                lcp_pkg::CMD_PREFETCH: begin
                    if (hit_reg) begin
                        ctrl.op = lcp_pkg::OP_HOLD;
                    end else if (full) begin
                        ctrl.op = lcp_pkg::OP_PRE_EVICT;
                    end else begin
                        ctrl.op = lcp_pkg::OP_PRE_INS;
                    end
                end
                default: begin
                    ctrl.op = lcp_pkg::OP_HOLD;
                end
            endcase
        end
    end

    // Result fields, counters and occupancy after the request.
    always_comb begin
        occ_next        = occ_reg;
        hits_next       = hits_reg;
        misses_next     = misses_reg;
        prefetches_next = prefetches_reg;
        group_next      = group_reg;
        res_hit         = 1'b0;
        res_load        = 1'b0;
        res_ev          = 1'b0;
        res_allp        = 1'b0;
        group_and       = group_reg && hit_reg;
        case (cmd_reg)
            lcp_pkg::CMD_FETCH: begin
                if (hit_reg) begin
                    res_hit   = 1'b1;
                    hits_next = hits_reg + 1'b1;
                end else begin
                    res_load    = 1'b1;
                    misses_next = misses_reg + 1'b1;
                    res_ev      = full;
                    if (!full) begin
                        occ_next = occ_reg + 1'b1;
                    end
                end
            end
            lcp_pkg::CMD_PREFETCH: begin
                if (hit_reg) begin
                    res_hit = 1'b1;
                end else begin
                    res_load        = 1'b1;
                    prefetches_next = prefetches_reg + 1'b1;
                    res_ev          = full;
                    if (!full) begin
                        occ_next = occ_reg + 1'b1;
                    end
                end
            end
            lcp_pkg::CMD_PROBE: begin
                res_hit = hit_reg;
                if (last_reg) begin
                    res_allp   = group_and;
                    group_next = 1'b1;
                end else begin
                    group_next = group_and;
                end
            end
            default: begin
                res_hit = 1'b0;
            end
        endcase
        res_ev_key   = res_ev ? cell_key[0] : '0;
        m_tdata_next = lcp_pkg::OUT_W'({prefetches_next, misses_next, hits_next,
                                        res_allp, res_ev_key, res_ev, res_load,
                                        res_hit});
    end

    // Sequencer, directory bookkeeping and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cap_reg        <= lcp_pkg::OCC_W'(lcp_pkg::CAP_RESET);
            occ_reg        <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            prefetches_reg <= '0;
            group_reg      <= 1'b1;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (cfg_fire) begin
                        cap_reg <= cap_next;
                        if (cap_next != cap_reg) begin
                            occ_reg <= '0;
                        end
                    end
                    if (s_fire) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (upd_fire) begin
                        occ_reg        <= occ_next;
                        hits_reg       <= hits_next;
                        misses_reg     <= misses_next;
                        prefetches_reg <= prefetches_next;
                        group_reg      <= group_next;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (upd_fire) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= m_tdata_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg     <= s_tdata[lcp_pkg::CMD_W-1:0];
            key_reg     <= s_tdata[lcp_pkg::CMD_W +: KB];
            last_reg    <= s_tlast;
            hit_reg     <= lookup_hit;
            hit_idx_reg <= lookup_idx;
        end
    end

endmodule

[rtl/core/lcp_cell.sv]
`timescale 1ns / 1ps
// One directory cell: holds the key at one recency position and shifts
// to or from its neighbors. Depends on lcp_pkg.
module lcp_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [lcp_pkg::IDX_W-1:0]      idx,
    input  logic [lcp_pkg::KEY_BITS-1:0]   lookup_key,
    input  lcp_pkg::cell_ctrl_t            ctrl,
    input  logic [lcp_pkg::KEY_BITS-1:0]   up_key,
    input  logic [lcp_pkg::KEY_BITS-1:0]   dn_key,
    input  logic                           dn_valid,
    output logic [lcp_pkg::KEY_BITS-1:0]   key,
    output logic                           valid,
    output logic                           match
);

    logic [lcp_pkg::KEY_BITS-1:0] key_reg;
    logic [lcp_pkg::KEY_BITS-1:0] key_next;
    logic                         valid_reg;
    logic                         valid_next;

    // Membership compare for the lookup cycle.
    assign match = valid_reg && (key_reg == lookup_key);
    assign key   = key_reg;
    assign valid = valid_reg;

    // Position 0 is the least recent entry; occupied positions are contiguous.
    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            lcp_pkg::OP_CLEAR: begin
                valid_next = 1'b0;
            end
            lcp_pkg::OP_FETCH_HIT: begin
                if (idx == ctrl.last_idx) begin
                    key_next = ctrl.key;
                end else if (idx >= ctrl.hit_idx && idx < ctrl.last_idx) begin
                    key_next = up_key;
                end
            end
            lcp_pkg::OP_FETCH_INS: begin
                if (lcp_pkg::OCC_W'(idx) == ctrl.occ) begin
                    key_next   = ctrl.key;
                    valid_next = 1'b1;
                end
            end
            lcp_pkg::OP_FETCH_EVICT: begin
                if (idx == ctrl.last_idx) begin
                    key_next = ctrl.key;
                end else if (idx < ctrl.last_idx) begin
                    key_next = up_key;
                end
            end
            lcp_pkg::OP_PRE_INS: begin
                if (idx == '0) begin
                    key_next   = ctrl.key;
                    valid_next = 1'b1;
                end else begin
                    key_next   = dn_key;
                    valid_next = dn_valid;
                end
            end
            lcp_pkg::OP_PRE_EVICT: begin
                if (idx == '0) begin
                    key_next = ctrl.key;
                end
            end
            default: begin
                key_next   = key_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // Key storage needs no reset; the valid bit does.
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

[rtl/core/lcp_match_tree.sv]
`timescale 1ns / 1ps
// Reduces the per-cell match flags to a hit flag and the position of the
// matching cell. Depends on lcp_pkg.
module lcp_match_tree (
    input  logic [lcp_pkg::MAX_ENTRIES-1:0] match,
    output logic                            hit,
    output logic [lcp_pkg::IDX_W-1:0]       hit_idx
);

    // Keys in the directory are distinct, so at most one flag is set and an
    // OR of the masked positions gives its index.
    always_comb begin
        hit_idx = '0;
        for (int j = 0; j < lcp_pkg::MAX_ENTRIES; j++) begin
            hit_idx = hit_idx | (match[j] ? lcp_pkg::IDX_W'(j) : '0);
        end
    end

    assign hit = |match;

endmodule

[tb/sv/lru_cache_with_prefetch_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the LRU key directory with prefetch.
// Depends on lcp_pkg and lru_cache_with_prefetch_top; it mirrors the directory
// as an ordered key list and checks every result transfer against it.
module lru_cache_with_prefetch_top_tb;

    // The block returns a result for this command code but leaves the directory and counters as they are.
    localparam logic [lcp_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam int IN_PAD_W       = lcp_pkg::IN_W - lcp_pkg::CMD_W - lcp_pkg::KEY_BITS;
    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        logic [lcp_pkg::CMD_W-1:0]    cmd;
        logic [lcp_pkg::KEY_BITS-1:0] key;
        logic                         last;
    } dir_request_t;

    typedef struct {
        logic                         hit;
        logic                         load_needed;
        logic                         evicted_valid;
        logic [lcp_pkg::KEY_BITS-1:0] evicted_key;
        logic                         all_present;
        logic [lcp_pkg::CNT_W-1:0]    hit_count;
        logic [lcp_pkg::CNT_W-1:0]    miss_count;
        logic [lcp_pkg::CNT_W-1:0]    prefetch_count;
    } dir_result_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [lcp_pkg::IN_W-1:0]   s_tdata   = '0;
    logic                       s_tlast   = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [lcp_pkg::OUT_W-1:0]  m_tdata;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [lcp_pkg::CAP_W-1:0]  cfg_data  = '0;

    lru_cache_with_prefetch_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Mirror of the directory: index 0 holds the least recent key.
    logic [lcp_pkg::KEY_BITS-1:0] lru_order[$];
    int                           dir_capacity = lcp_pkg::CAP_RESET;
    logic [lcp_pkg::CNT_W-1:0]    hits_seen = '0;
    logic [lcp_pkg::CNT_W-1:0]    misses_seen = '0;
    logic [lcp_pkg::CNT_W-1:0]    prefetches_seen = '0;
    logic                         group_and = 1'b1;

    dir_request_t pending_reqs[$];
    dir_result_t  exp_results[$];
    dir_request_t drv_req;
    dir_result_t  want;

    logic steady = 1'b0;
    int   errors = 0;
    int   n_requests = 0;
    int   n_results = 0;
    int   n_cfg = 0;
    int   n_evictions = 0;
    int   n_full_groups = 0;
    int   idle_cycles = 0;

    // Clamp a capacity write; a changed value empties the directory.
    task automatic apply_capacity(input logic [lcp_pkg::CAP_W-1:0] value);
        int c;
        c = int'(value);
        if (c == 0) c = 1;
        if (c > lcp_pkg::MAX_ENTRIES) c = lcp_pkg::MAX_ENTRIES;
        if (c != dir_capacity) begin
            lru_order.delete();
            dir_capacity = c;
        end
    endtask

    // Update the mirror for one accepted request and queue its result.
    task automatic predict_request(input dir_request_t r);
        dir_result_t e;
        int          pos;
        e = '{default: '0};
        pos = -1;
        foreach (lru_order[i]) begin
            if (lru_order[i] == r.key) pos = i;
        end
        case (r.cmd)
            lcp_pkg::CMD_FETCH: begin
                if (pos >= 0) begin
                    e.hit = 1'b1;
                    hits_seen++;
                    lru_order.delete(pos);
                end else begin
                    misses_seen++;
                    e.load_needed = 1'b1;
                    if (lru_order.size() >= dir_capacity) begin
                        e.evicted_valid = 1'b1;
                        e.evicted_key = lru_order[0];
                        lru_order.delete(0);
                        n_evictions++;
                    end
                end
                lru_order.push_back(r.key);
            end
            lcp_pkg::CMD_PREFETCH: begin
                if (pos >= 0) begin
                    e.hit = 1'b1;
                end else begin
                    e.load_needed = 1'b1;
                    if (lru_order.size() >= dir_capacity) begin
                        e.evicted_valid = 1'b1;
                        e.evicted_key = lru_order[0];
                        lru_order.delete(0);
                        n_evictions++;
                    end
                    lru_order.push_front(r.key);
                    prefetches_seen++;
                end
            end
            lcp_pkg::CMD_PROBE: begin
                e.hit = (pos >= 0);
                group_and = group_and & e.hit;
                if (r.last) begin
                    e.all_present = group_and;
                    if (group_and) n_full_groups++;
                    group_and = 1'b1;
                end
            end
            default: ;
        endcase
        e.hit_count = hits_seen;
        e.miss_count = misses_seen;
        e.prefetch_count = prefetches_seen;
        exp_results.push_back(e);
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", n_results, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got 0x%08h, expected 0x%08h", name, got, exp_val));
    endtask

    task automatic add_req(input logic [lcp_pkg::CMD_W-1:0] cmd,
                           input logic [lcp_pkg::KEY_BITS-1:0] key,
                           input logic last);
        dir_request_t r;
        r.cmd = cmd;
        r.key = key;
        r.last = last;
        pending_reqs.push_back(r);
    endtask

    // Wait until every request has been answered, then a few quiet cycles.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_tvalid || exp_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [lcp_pkg::CAP_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        apply_capacity(value);
        n_cfg++;
        cfg_valid <= 1'b0;
    endtask

    // Mostly fetches and prefetches over a key pool a bit larger than the
    // capacity, probe groups drawn from the same pool, plus stray probes and
    // ignored commands as noise.
    task automatic queue_random_phase(input int n_items, input int cap);
        logic [lcp_pkg::KEY_BITS-1:0] pool[];
        int                           count;
        int                           roll;
        int                           len;
        logic [lcp_pkg::KEY_BITS-1:0] key;
        pool = new[cap + cap / 4 + 2];
        foreach (pool[i]) pool[i] = $urandom;
        count = 0;
        while (count < n_items) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) key = $urandom;
            else key = pool[$urandom_range(0, pool.size() - 1)];
            if (roll < 45) begin
                add_req(lcp_pkg::CMD_FETCH, key, 1'($urandom_range(0, 1)));
                count++;
            end else if (roll < 68) begin
                add_req(lcp_pkg::CMD_PREFETCH, key, 1'($urandom_range(0, 1)));
                count++;
            end else if (roll < 90) begin
                len = $urandom_range(1, 3);
                for (int g = 0; g < len; g++) begin
                    add_req(lcp_pkg::CMD_PROBE, pool[$urandom_range(0, pool.size() - 1)],
                            g == len - 1);
                    count++;
                end
            end else if (roll < 95) begin
                add_req(lcp_pkg::CMD_PROBE, key, 1'($urandom_range(0, 1)));
                count++;
            end else begin
                add_req(CMD_UNKNOWN, $urandom, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Driver: present queued requests, predicting each one on its transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_request(drv_req);
                n_requests++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 30)) begin
                    drv_req = pending_reqs[0];
                    pending_reqs.delete(0);
                    s_tdata <= {{IN_PAD_W{1'b0}}, drv_req.key, drv_req.cmd};
                    s_tlast <= drv_req.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_results.size() == 0) begin
                report_mismatch("result transfer with no request outstanding");
            end else begin
                want = exp_results[0];
                exp_results.delete(0);
                check_field("hit", 32'(m_tdata[0]), 32'(want.hit));
                check_field("load_needed", 32'(m_tdata[1]), 32'(want.load_needed));
                check_field("evicted_valid", 32'(m_tdata[2]), 32'(want.evicted_valid));
                check_field("evicted_key", m_tdata[34:3], want.evicted_key);
                check_field("all_present", 32'(m_tdata[35]), 32'(want.all_present));
                check_field("hit_count", m_tdata[67:36], want.hit_count);
                check_field("miss_count", m_tdata[99:68], want.miss_count);
                check_field("prefetch_count", m_tdata[131:100], want.prefetch_count);
            end
            n_results++;
        end
        m_tready <= steady || ($urandom_range(0, 99) >= 30);
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Phase sequencing: directed requests, then random phases per capacity.
    initial begin
        logic [lcp_pkg::CAP_W-1:0] caps[9];
        int                        n_phase;
        caps = '{7'd127, 7'd64, 7'd1, 7'd3, 7'd100, 7'd8, 7'd5, 7'd16, 7'd0};
        caps[8] = 7'($urandom_range(0, 127));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Full-size directory: hits, misses, prefetch hit and insert, groups.
        add_req(lcp_pkg::CMD_FETCH, 32'h0000_0000, 1'b0);
        add_req(lcp_pkg::CMD_FETCH, 32'hFFFF_FFFF, 1'b1);
        add_req(lcp_pkg::CMD_FETCH, 32'h0000_0000, 1'b0);
        add_req(lcp_pkg::CMD_PREFETCH, 32'hFFFF_FFFF, 1'b0);
        add_req(lcp_pkg::CMD_PREFETCH, 32'h1234_5678, 1'b1);
        add_req(lcp_pkg::CMD_PROBE, 32'h0000_0000, 1'b0);
        add_req(lcp_pkg::CMD_FETCH, 32'h0000_0007, 1'b0);
        add_req(lcp_pkg::CMD_PROBE, 32'h1234_5678, 1'b1);
        add_req(lcp_pkg::CMD_PROBE, 32'h0000_0005, 1'b0);
        add_req(lcp_pkg::CMD_PROBE, 32'h0000_0000, 1'b1);
        add_req(CMD_UNKNOWN, 32'hFFFF_FFFF, 1'b1);
        add_req(lcp_pkg::CMD_PROBE, 32'hFFFF_FFFF, 1'b1);
        wait_idle();

        // Two entries: eviction on fetch and on prefetch when full.
        write_capacity(7'd2);
        add_req(lcp_pkg::CMD_FETCH, 32'h0000_0001, 1'b0);
        add_req(lcp_pkg::CMD_PREFETCH, 32'h0000_0002, 1'b0);
        add_req(lcp_pkg::CMD_FETCH, 32'h0000_0003, 1'b0);
        add_req(lcp_pkg::CMD_FETCH, 32'h0000_0001, 1'b0);
        add_req(lcp_pkg::CMD_PREFETCH, 32'h0000_0004, 1'b0);
        add_req(lcp_pkg::CMD_FETCH, 32'h0000_0005, 1'b0);
        add_req(CMD_UNKNOWN, 32'h0000_0000, 1'b0);
        wait_idle();

        // A written zero behaves as one entry.
        write_capacity(7'd0);
        add_req(lcp_pkg::CMD_FETCH, 32'hAAAA_AAAA, 1'b0);
        add_req(lcp_pkg::CMD_PREFETCH, 32'h5555_5555, 1'b1);
        add_req(lcp_pkg::CMD_FETCH, 32'h5555_5555, 1'b0);
        add_req(lcp_pkg::CMD_PROBE, 32'h5555_5555, 1'b1);
        wait_idle();

        foreach (caps[p]) begin
            write_capacity(caps[p]);
            steady = (p == 4);
            n_phase = (dir_capacity == lcp_pkg::MAX_ENTRIES) ? 130 : 70;
            queue_random_phase(n_phase, dir_capacity);
            wait_idle();
        end
        steady = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (exp_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", exp_results.size()));

        $display("Covered %0d requests and %0d results over %0d capacity writes.",
                 n_requests, n_results, n_cfg);
        $display("Fetch hits %0d, misses %0d, prefetch inserts %0d, evictions %0d, %s %0d.",
                 hits_seen, misses_seen, prefetches_seen, n_evictions, "full groups",
                 n_full_groups);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
